[src/ptw_pkg.sv]
// Shared constants, status codes and index selection for the page table walker.
package ptw_pkg;

  localparam int TABLE_FRAMES_DEF = 64;
  localparam int ENTRIES          = 512;
  localparam int IDX_W            = $clog2(ENTRIES);
  localparam int ADDR_W           = 48;
  localparam int PAGE_SHIFT       = 12;
  localparam int BIG_SHIFT        = 21;
  localparam int PFN_W            = ADDR_W - PAGE_SHIFT;
  localparam int FLAGS_W          = 12;
  localparam int ENTRY_W          = PFN_W + FLAGS_W;
  localparam int FRAME_PORT_W     = 6;
  localparam int STATUS_W         = 2;
  localparam int LEVEL_W          = 2;

  localparam int FLAG_PRESENT = 0;
  localparam int FLAG_USER    = 2;
  localparam int FLAG_BIG     = 7;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_1 = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_2 = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_3 = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_4 = 2'd3;

  function automatic logic [IDX_W-1:0] level_index(input logic [ADDR_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_4:   idx = va[47:39];
      LVL_3:   idx = va[38:30];
      LVL_2:   idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

[src/four_level_page_table_walker.sv]
// Four-level page table walker with an on-chip table store.
//
// Command channel: an item transfers at a rising edge with start high and
// busy low. kind 0 writes one table entry ({target_addr[47:12], entry_flags})
// into table_frame at entry_index; kind 1 walks from root_frame for virt_addr.
// Each item gives one result, shown on phys_addr, status and user_access for
// exactly one cycle while done is high; the receiver cannot stall.
// Timing: a write reports in the cycle after its transfer and busy stays
// low, so one write per cycle is possible. A translation reads the store once
// per visited level from a single read port, one level per cycle. A root
// outside the store reports like a write; a walk ends at a leaf, big page,
// missing entry or outside child frame; busy is high until the result cycle.
// Reset: rst clears the control state and starts a clearing pass that writes
// zero to every entry, one per cycle; busy stays high during the pass.
// status: 0 ok, 1 not mapped, 2 table frame outside the store.
module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [ptw_pkg::FRAME_PORT_W-1:0]  table_frame,
  input  logic [ptw_pkg::IDX_W-1:0]         entry_index,
  input  logic [ptw_pkg::ADDR_W-1:0]        target_addr,
  input  logic [ptw_pkg::FLAGS_W-1:0]       entry_flags,
  input  logic [ptw_pkg::ADDR_W-1:0]        virt_addr,
  input  logic [ptw_pkg::FRAME_PORT_W-1:0]  root_frame,
  output logic                              done,
  output logic [ptw_pkg::ADDR_W-1:0]        phys_addr,
  output logic [ptw_pkg::STATUS_W-1:0]      status,
  output logic                              user_access
);
  import ptw_pkg::*;

  localparam int DEPTH = TABLE_FRAMES * ENTRIES;
  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int AW    = FW + IDX_W;
  localparam logic [PFN_W-1:0] FRAME_LIMIT = PFN_W'(TABLE_FRAMES);
  localparam logic [AW-1:0]    LAST_ADDR   = AW'(DEPTH - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [1:0]          state, state_next;
  logic [AW-1:0]       clr_addr;
  logic [LEVEL_W-1:0]  level, level_next;
  logic [ADDR_W-1:0]   va;
  logic                user, user_next;

  logic                done_next;
  logic [ADDR_W-1:0]   phys_next;
  logic [STATUS_W-1:0] status_next;
  logic                user_access_next;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [AW-1:0]       rd_addr;

  logic                accept;
  logic [PFN_W-1:0]    wr_frame_ext, root_ext, child;
  logic [ENTRY_W-1:0]  e;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign e      = rd_data;
  assign child  = e[ENTRY_W-1:FLAGS_W];
  assign wr_frame_ext = {{(PFN_W-FRAME_PORT_W){1'b0}}, table_frame};
  assign root_ext     = {{(PFN_W-FRAME_PORT_W){1'b0}}, root_frame};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (accept && !kind) begin
      wr_en   = (wr_frame_ext < FRAME_LIMIT);
      wr_addr = {wr_frame_ext[FW-1:0], entry_index};
      wr_data = {target_addr[ADDR_W-1:PAGE_SHIFT], entry_flags};
    end
  end

  always_comb begin
    state_next       = state;
    level_next       = level;
    user_next        = user;
    done_next        = 1'b0;
    phys_next        = phys_addr;
    status_next      = status;
    user_access_next = user_access;
    rd_addr          = {root_ext[FW-1:0], level_index(virt_addr, LVL_4)};
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!kind) begin
            done_next        = 1'b1;
            phys_next        = '0;
            status_next      = ST_OK;
            user_access_next = 1'b0;
          end else if (root_ext >= FRAME_LIMIT) begin
            done_next        = 1'b1;
            phys_next        = '0;
            status_next      = ST_OUTSIDE;
            user_access_next = 1'b0;
          end else begin
            state_next = S_WALK;
            level_next = LVL_4;
            user_next  = 1'b1;
          end
        end
      end
      S_WALK: begin
        rd_addr = {child[FW-1:0], level_index(va, level - 2'd1)};
        if (!e[FLAG_PRESENT]) begin
          done_next        = 1'b1;
          phys_next        = '0;
          status_next      = ST_NOT_MAPPED;
          user_access_next = 1'b0;
          state_next       = S_IDLE;
        end else if (level == LVL_2 && e[FLAG_BIG]) begin
          done_next        = 1'b1;
          phys_next        = {e[ENTRY_W-1:FLAGS_W+BIG_SHIFT-PAGE_SHIFT], va[BIG_SHIFT-1:0]};
          status_next      = ST_OK;
          user_access_next = user && e[FLAG_USER];
          state_next       = S_IDLE;
        end else if (level == LVL_1) begin
          done_next        = 1'b1;
          phys_next        = {child, va[PAGE_SHIFT-1:0]};
          status_next      = ST_OK;
          user_access_next = user && e[FLAG_USER];
          state_next       = S_IDLE;
        end else if (child >= FRAME_LIMIT) begin
          done_next        = 1'b1;
          phys_next        = '0;
          status_next      = ST_OUTSIDE;
          user_access_next = 1'b0;
          state_next       = S_IDLE;
        end else begin
          level_next = level - 2'd1;
          user_next  = user && e[FLAG_USER];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    level       <= level_next;
    user        <= user_next;
    phys_addr   <= phys_next;
    status      <= status_next;
    user_access <= user_access_next;
    if (accept) begin
      va <= virt_addr;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |=> (done && status == ST_OK && phys_addr == '0 && !user_access))
    else $error("write transfer did not report");

  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (phys_addr == '0 && !user_access))
    else $error("failed walk with nonzero address or user flag");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (state != S_WALK || level == $past(level) - 2'd1))
    else $error("walk level did not advance");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NOT_MAPPED || status == ST_OUTSIDE))
    else $error("undefined status code");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the four-level page table walker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam int FRAMES = TABLE_FRAMES_DEF;
  localparam int STALL_LIMIT = 200000;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_WALK = 1'b1;
  localparam logic [FLAGS_W-1:0] FL_P = FLAGS_W'(1) << FLAG_PRESENT;
  localparam logic [FLAGS_W-1:0] FL_U = FLAGS_W'(1) << FLAG_USER;
  localparam logic [FLAGS_W-1:0] FL_BIG = FLAGS_W'(1) << FLAG_BIG;

  typedef struct packed {
    logic [ADDR_W-1:0]   phys;
    logic [STATUS_W-1:0] st;
    logic                user;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = KIND_WRITE;
  logic [FRAME_PORT_W-1:0] table_frame = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [ADDR_W-1:0] target_addr = '0;
  logic [FLAGS_W-1:0] entry_flags = '0;
  logic [ADDR_W-1:0] virt_addr = '0;
  logic [FRAME_PORT_W-1:0] root_frame = '0;
  logic done;
  logic [ADDR_W-1:0] phys_addr;
  logic [STATUS_W-1:0] status;
  logic user_access;

  logic [ENTRY_W-1:0] page_tables [0:FRAMES*ENTRIES-1];
  walk_result_t pending_results[$];
  int items_sent = 0;
  int idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  four_level_page_table_walker uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .table_frame(table_frame), .entry_index(entry_index), .target_addr(target_addr),
    .entry_flags(entry_flags), .virt_addr(virt_addr), .root_frame(root_frame),
    .done(done), .phys_addr(phys_addr), .status(status), .user_access(user_access)
  );

  always #6ns clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic walk_result_t predict_walk(input logic [ADDR_W-1:0] va,
                                                input logic [FRAME_PORT_W-1:0] root);
    logic [PFN_W-1:0] frame;
    logic [ENTRY_W-1:0] e;
    logic [IDX_W-1:0] idx;
    logic user;
    frame = PFN_W'(root);
    user = 1'b1;
    if (frame >= FRAMES) return walk_result_t'{48'd0, ST_OUTSIDE, 1'b0};
    for (int lvl = 4; lvl >= 1; lvl--) begin
      idx = va[PAGE_SHIFT + IDX_W*(lvl-1) +: IDX_W];
      e = page_tables[frame*ENTRIES + idx];
      if (!e[FLAG_PRESENT]) return walk_result_t'{48'd0, ST_NOT_MAPPED, 1'b0};
      if (!e[FLAG_USER]) user = 1'b0;
      if (lvl == 2 && e[FLAG_BIG])
        return walk_result_t'{{e[ENTRY_W-1:BIG_SHIFT], va[BIG_SHIFT-1:0]}, ST_OK, user};
      if (lvl == 1)
        return walk_result_t'{{e[ENTRY_W-1:FLAGS_W], va[PAGE_SHIFT-1:0]}, ST_OK, user};
      frame = e[ENTRY_W-1:FLAGS_W];
      if (frame >= FRAMES) return walk_result_t'{48'd0, ST_OUTSIDE, 1'b0};
    end
    return walk_result_t'{48'd0, ST_NOT_MAPPED, 1'b0};
  endfunction

  task automatic send_item(input logic k, input logic [FRAME_PORT_W-1:0] tf,
                           input logic [IDX_W-1:0] ei, input logic [ADDR_W-1:0] ta,
                           input logic [FLAGS_W-1:0] fl, input logic [ADDR_W-1:0] va,
                           input logic [FRAME_PORT_W-1:0] rf);
    walk_result_t exp_res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    kind <= k;
    table_frame <= tf;
    entry_index <= ei;
    target_addr <= ta;
    entry_flags <= fl;
    virt_addr <= va;
    root_frame <= rf;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (k == KIND_WRITE) begin
      if (tf < FRAMES) page_tables[tf*ENTRIES + ei] = {ta[ADDR_W-1:PAGE_SHIFT], fl};
      exp_res = walk_result_t'{48'd0, ST_OK, 1'b0};
    end else begin
      exp_res = predict_walk(va, rf);
    end
    pending_results.push_back(exp_res);
    items_sent++;
  endtask

  task automatic write_entry(input logic [FRAME_PORT_W-1:0] tf, input logic [IDX_W-1:0] ei,
                             input logic [ADDR_W-1:0] ta, input logic [FLAGS_W-1:0] fl);
    send_item(KIND_WRITE, tf, ei, ta, fl, rand48(), FRAME_PORT_W'($urandom));
  endtask

  task automatic translate(input logic [ADDR_W-1:0] va, input logic [FRAME_PORT_W-1:0] rf);
    send_item(KIND_WALK, FRAME_PORT_W'($urandom), IDX_W'($urandom), rand48(),
              FLAGS_W'($urandom), va, rf);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_entry_writes();
    write_entry(6'd63, 9'd511, 48'hFFFF_FFFF_FFFF, 12'hFFF);
    write_entry(6'd0, 9'd0, 48'd0, 12'h000);
  endtask

  task automatic test_empty_and_root_walks();
    translate(48'hFFFF_FFFF_FFFF, 6'd5);
    translate(48'd0, 6'd63);
    translate({9'd511, 39'd0}, 6'd63);
  endtask

  task automatic test_full_walk();
    write_entry(6'd10, 9'd7, {30'd0, 6'd11, 12'hABC}, FL_P | FL_U | FL_BIG);
    write_entry(6'd11, 9'd300, {30'd0, 6'd12, 12'h000}, FL_P | FL_U | FL_BIG);
    write_entry(6'd12, 9'd5, {30'd0, 6'd13, 12'h000}, FL_P | FL_U);
    write_entry(6'd13, 9'd511, 48'hABCD_EF12_3000, FL_P | FL_U | FL_BIG);
    translate({9'd7, 9'd300, 9'd5, 9'd511, 12'hFFF}, 6'd10);
  endtask

  task automatic test_big_page();
    write_entry(6'd12, 9'd6, 48'h1234_5678_9FFF, FL_P | FL_BIG);
    translate({9'd7, 9'd300, 9'd6, 21'h1F_FFFF}, 6'd10);
  endtask

  task automatic test_child_outside();
    write_entry(6'd11, 9'd301, 48'h0000_0004_0000, FL_P);
    translate({9'd7, 9'd301, 30'h2AAA_AAAA}, 6'd10);
    write_entry(6'd12, 9'd7, 48'hFFFF_FFFF_F000, FL_P | FL_U);
    translate({9'd7, 9'd300, 9'd7, 21'h0}, 6'd10);
  endtask

  task automatic test_not_present();
    translate({9'd7, 9'd300, 9'd8, 21'h15555}, 6'd10);
    write_entry(6'd13, 9'd0, 48'h0000_0000_5000, FL_U | FL_BIG);
    translate({9'd7, 9'd300, 9'd5, 9'd0, 12'h123}, 6'd10);
  endtask

  task automatic test_user_cleared();
    write_entry(6'd12, 9'd5, {30'd0, 6'd13, 12'h000}, FL_P);
    translate({9'd7, 9'd300, 9'd5, 9'd511, 12'h000}, 6'd10);
  endtask

  task automatic test_random_walks(input int item_target);
    logic [FRAME_PORT_W-1:0] frames [0:3];
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] addr;
    logic [FLAGS_W-1:0] fl;
    int pick;
    while (items_sent < item_target) begin
      for (int k = 0; k < 4; k++) frames[k] = FRAME_PORT_W'($urandom);
      va = rand48();
      pick = $urandom_range(99);
      if (pick < 10) begin
        write_entry(FRAME_PORT_W'($urandom), IDX_W'($urandom), rand48(), FLAGS_W'($urandom));
      end else if (pick < 15) begin
        translate(rand48(), FRAME_PORT_W'($urandom));
      end else begin
        for (int lvl = 4; lvl >= 1; lvl--) begin
          fl = FLAGS_W'($urandom);
          fl[FLAG_PRESENT] = ($urandom_range(99) < 94);
          fl[FLAG_USER] = ($urandom_range(99) < 85);
          if (lvl == 2) fl[FLAG_BIG] = ($urandom_range(99) < 25);
          if (lvl == 1 || (lvl == 2 && fl[FLAG_BIG]) || $urandom_range(99) < 5)
            addr = rand48();
          else
            addr = {30'd0, frames[5-lvl], 12'($urandom)};
          write_entry(frames[4-lvl], va[PAGE_SHIFT + IDX_W*(lvl-1) +: IDX_W], addr, fl);
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1) == 1)
            translate({va[ADDR_W-1:BIG_SHIFT], 21'($urandom)}, frames[0]);
          else
            translate({va[ADDR_W-1:PAGE_SHIFT], 12'($urandom)}, frames[0]);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    walk_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transfer", '0, phys_addr);
      end else begin
        exp_res = pending_results.pop_front();
        if (phys_addr !== exp_res.phys) note_mismatch("phys_addr", exp_res.phys, phys_addr);
        if (status !== exp_res.st)
          note_mismatch("status", ADDR_W'(exp_res.st), ADDR_W'(status));
        if (user_access !== exp_res.user)
          note_mismatch("user_access", ADDR_W'(exp_res.user), ADDR_W'(user_access));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < FRAMES*ENTRIES; i++) page_tables[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    test_entry_writes();
    test_empty_and_root_walks();
    test_full_walk();
    test_big_page();
    test_child_outside();
    test_not_present();
    test_user_cleared();
    wait_for_results();
    test_random_walks(650);
    wait_for_results();
    idle_pct = 76;
    test_random_walks(1300);
    wait_for_results();
    idle_pct = 0;
    test_random_walks(1950);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
